@@ hw/rtl/ocr_pkg.sv @@
// Shared types, codes and constants of the overcurrent trip block.
// No dependencies; every other file of the block imports this package.
package ocr_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 12;
   localparam int LEVEL_W  = 12;
   localparam int COUNT_W  = 8;
   localparam int SUM_W    = 18;
   localparam int TAKEN_W  = 6;
   localparam int CSR_W    = 12;

   // Window size range and default
   localparam int SPW_DEFAULT = 50;
   localparam int SPW_MAX     = 63;

   // Reciprocal scaling for the window division (exact for all sums of SUM_W bits)
   localparam int RECIP_SHIFT = SUM_W + TAKEN_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   // Register reset values
   localparam logic [LEVEL_W-1:0] TRIP_LEVEL_RESET      = 12'd3584;
   localparam logic [COUNT_W-1:0] RECOVERY_CHECKS_RESET = 8'd40;

   // Configuration register indexes
   localparam logic REG_TRIP_LEVEL      = 1'b0;
   localparam logic REG_RECOVERY_CHECKS = 1'b1;

   // Stream widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_BITS   = 17;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      OP_SAMPLE    = 2'd0,
      OP_POWER_ON  = 2'd1,
      OP_POWER_OFF = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_TRIP  = 2'd1,
      EV_RETRY = 2'd2
   } event_type;

   // Input item as held in the input register
   typedef struct packed {
      op_type              operation;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   // Result item; the last member sits in the lowest bit of tdata
   typedef struct packed {
      event_type          event_res;
      logic [LEVEL_W-1:0] last_average;
      logic               window_done;
      logic               faulted;
      logic               power_enabled;
   } rsp_type;

endpackage

@@ hw/rtl/ocr_req_reg.sv @@
// Input register of the overcurrent trip block: captures one item per cycle
// while it is empty or its item moves on. Depends on ocr_pkg.
module ocr_req_reg
   import ocr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  advance,
   output logic                  in_valid,
   output req_type               in_item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   // The register takes a new item when empty or when its item moves on
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tvalid && req_tready) begin
         valid_in          = 1'b1;
         item_in.operation = op_type'(req_tuser[1:0]);
         item_in.sample    = req_tdata[SAMPLE_W-1:0];
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign in_valid = valid_ff;
   assign in_item  = item_ff;

endmodule

@@ hw/rtl/ocr_core.sv @@
// Protection state and per-item logic: window averaging, trip check and retry countdown.
// Also holds the configuration registers. Depends on ocr_pkg.
module ocr_core
   import ocr_pkg::*;
#(
   parameter int SAMPLES_PER_WINDOW = SPW_DEFAULT
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             advance,
   input  req_type          in_item,
   output rsp_type          result
);

   // Window size clamped to the counter range
   localparam int WIN = (SAMPLES_PER_WINDOW < 1) ? 1 :
                        ((SAMPLES_PER_WINDOW > SPW_MAX) ? SPW_MAX : SAMPLES_PER_WINDOW);
   localparam logic [TAKEN_W:0]   WIN_CMP = (TAKEN_W+1)'(WIN);
   localparam logic [RECIP_W-1:0] RECIP   =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WIN) - 64'd1) / 64'(WIN));

   logic [LEVEL_W-1:0] trip_level_ff;
   logic [COUNT_W-1:0] recovery_checks_ff;

   logic               enable_ff, enable_in;
   logic               fault_ff, fault_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TAKEN_W-1:0] taken_ff, taken_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [LEVEL_W-1:0] avg_ff, avg_in;

   logic [SUM_W-1:0]           sum_add;
   logic [TAKEN_W-1:0]         taken_inc;
   logic [SUM_W+RECIP_W-1:0]   product;
   logic [LEVEL_W-1:0]         avg_new;
   logic                       done;
   event_type                  ev;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         trip_level_ff      <= TRIP_LEVEL_RESET;
         recovery_checks_ff <= RECOVERY_CHECKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_TRIP_LEVEL:      trip_level_ff      <= csr_wdata[LEVEL_W-1:0];
            REG_RECOVERY_CHECKS: recovery_checks_ff <= csr_wdata[COUNT_W-1:0];
            default:             trip_level_ff      <= trip_level_ff;
         endcase
      end
   end

   // Accumulate and divide the window sum by multiplying with its reciprocal
   assign sum_add   = sum_ff + in_item.sample;
   assign taken_inc = taken_ff + 1'b1;
   assign product   = sum_add * RECIP;
   assign avg_new   = product[RECIP_SHIFT +: LEVEL_W];

   // Next state and event for the item in the input register
   always_comb begin
      enable_in = enable_ff;
      fault_in  = fault_ff;
      sum_in    = sum_ff;
      taken_in  = taken_ff;
      left_in   = left_ff;
      avg_in    = avg_ff;
      done      = 1'b0;
      ev        = EV_NONE;
      case (in_item.operation)
         OP_SAMPLE: begin
            sum_in   = sum_add;
            taken_in = taken_inc;
            if ({1'b0, taken_inc} >= WIN_CMP) begin
               avg_in   = avg_new;
               sum_in   = '0;
               taken_in = '0;
               done     = 1'b1;
               if (avg_new >= trip_level_ff) begin
                  // High average: trip if powered, else reload a pending countdown
                  if (enable_ff) begin
                     enable_in = 1'b0;
                     fault_in  = 1'b1;
                     left_in   = recovery_checks_ff;
                     ev        = EV_TRIP;
                  end else if (fault_ff) begin
                     left_in = recovery_checks_ff;
                  end
               end else if (fault_ff) begin
                  // Low average while faulted: count down, re-enable at the end
                  if (left_ff <= COUNT_W'(1)) begin
                     left_in   = '0;
                     enable_in = 1'b1;
                     fault_in  = 1'b0;
                     ev        = EV_RETRY;
                  end else begin
                     left_in = left_ff - 1'b1;
                  end
               end
            end
         end
         OP_POWER_ON: begin
            enable_in = 1'b1;
         end
         OP_POWER_OFF: begin
            enable_in = 1'b0;
            fault_in  = 1'b0;
            left_in   = '0;
         end
         default: begin
            enable_in = enable_ff;
         end
      endcase
   end

   // State registers advance with each item
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         fault_ff  <= 1'b0;
         sum_ff    <= '0;
         taken_ff  <= '0;
         left_ff   <= '0;
         avg_ff    <= '0;
      end else if (advance) begin
         enable_ff <= enable_in;
         fault_ff  <= fault_in;
         sum_ff    <= sum_in;
         taken_ff  <= taken_in;
         left_ff   <= left_in;
         avg_ff    <= avg_in;
      end
   end

   // Result of this item
   always_comb begin
      result.power_enabled = enable_in;
      result.faulted       = fault_in;
      result.window_done   = done;
      result.last_average  = avg_in;
      result.event_res     = ev;
   end

endmodule

@@ hw/rtl/ocr_rsp_reg.sv @@
// Result register of the overcurrent trip block, decoupling the result side.
// Depends on ocr_pkg.
module ocr_rsp_reg
   import ocr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rsp_type               result,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // Room for a new result when empty or when the held one is taken now
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-RSP_BITS)'(0), data_ff};

endmodule

@@ hw/rtl/overcurrent_trip_with_auto_retry.sv @@
// Overcurrent trip with automatic retry. One item per cycle sustained throughput.
// An item taken sits in the input register; the single pass of averaging and
// checks is combinational, and its result loads into the result register, from
// which it is offered. A held result stalls input.
// Synchronous active-high reset: power off, no fault, empty window, config at
// reset values (trip level 3584, recovery checks 40). Depends on ocr_pkg.
module overcurrent_trip_with_auto_retry
   import ocr_pkg::*;
#(
   parameter int SAMPLES_PER_WINDOW = SPW_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Configuration write port
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   // Input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [11:0] sample, [15:12] ignored
   input  logic [REQ_USER_W-1:0] req_tuser,  // [1:0] operation
   // Result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] power_enabled, [1] faulted, [2] window_done, [14:3] last_average,
   // [16:15] event_res, [23:17] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic    in_valid;
   req_type in_item;
   logic    rsp_free;
   logic    advance;
   rsp_type result;

   // An item moves through the core when the result register can take it
   assign advance = in_valid && rsp_free;

   ocr_req_reg u_req (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .in_valid   (in_valid),
      .in_item    (in_item)
   );

   ocr_core #(
      .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .in_item   (in_item),
      .result    (result)
   );

   ocr_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hw/rtl/ocr_checker.sv @@
// Port-level checks on the result stream of the overcurrent trip block,
// bound to the top level. Depends on ocr_pkg.
module ocr_checker
   import ocr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_type r;
   assign r = rsp_type'(rsp_tdata[RSP_BITS-1:0]);

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A trip leaves power off with the fault pending
   a_trip: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r.event_res == EV_TRIP |-> !r.power_enabled && r.faulted)
      else $error("trip without power cut and fault");

   // A retry re-enables power and clears the fault
   a_retry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r.event_res == EV_RETRY |-> r.power_enabled && !r.faulted)
      else $error("retry without re-enable");

   // Events only arise from a completed window
   a_event_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r.event_res != EV_NONE |-> r.window_done)
      else $error("event outside a window check");

endmodule

bind overcurrent_trip_with_auto_retry ocr_checker u_ocr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
